### rtl/psd_pkg.sv
// Shared constants, types and region codes for the point-segment distance block.
package psd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_BITS  = 33;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int QW     = SQ_W + FRAC_BITS;
    localparam int NUM_W  = 2 * SQ_W + FRAC_BITS;
    localparam int VAL_W  = (QW > DIST_BITS) ? QW : DIST_BITS;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // start to done: four front stages, queue, divider input register fed by the
    // square, one divider stage per quotient bit, output register
    localparam int LATENCY = QW + 7;

    localparam logic [1:0] REGION_DEGEN    = 2'd0;
    localparam logic [1:0] REGION_START    = 2'd1;
    localparam logic [1:0] REGION_END      = 2'd2;
    localparam logic [1:0] REGION_INTERIOR = 2'd3;

    typedef struct packed {
        logic [1:0]      region;
        logic [SQ_W-1:0] len2;
        logic [SQ_W-1:0] edist;
        logic [SQ_W-1:0] cross_mag;
    } entry_t;

endpackage

### rtl/psd_front.sv
// Front end: differences, products, sums and region classification.
module psd_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_y,
    output logic                                 entry_valid,
    output psd_pkg::entry_t                      entry
);
    import psd_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PROD_W-1:0] axdx_reg, aydy_reg, axdy_reg, aydx_reg;
    logic signed [PROD_W-1:0] dxdx_reg, dydy_reg, axax_reg, ayay_reg, bxbx_reg, byby_reg;
    logic signed [SUM_W-1:0]  dot_reg, cross_reg;
    logic [SQ_W-1:0]          len2_reg, a2_reg, b2_reg;
    entry_t                   entry_reg, entry_next;
    logic signed [SUM_W-1:0]  cross_abs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= DIFF_W'(end_x) - DIFF_W'(start_x);
        dy_reg <= DIFF_W'(end_y) - DIFF_W'(start_y);
        ax_reg <= DIFF_W'(point_x) - DIFF_W'(start_x);
        ay_reg <= DIFF_W'(point_y) - DIFF_W'(start_y);
        bx_reg <= DIFF_W'(point_x) - DIFF_W'(end_x);
        by_reg <= DIFF_W'(point_y) - DIFF_W'(end_y);

        axdx_reg <= ax_reg * dx_reg;
        aydy_reg <= ay_reg * dy_reg;
        axdy_reg <= ax_reg * dy_reg;
        aydx_reg <= ay_reg * dx_reg;
        dxdx_reg <= dx_reg * dx_reg;
        dydy_reg <= dy_reg * dy_reg;
        axax_reg <= ax_reg * ax_reg;
        ayay_reg <= ay_reg * ay_reg;
        bxbx_reg <= bx_reg * bx_reg;
        byby_reg <= by_reg * by_reg;

        dot_reg   <= SUM_W'(axdx_reg) + SUM_W'(aydy_reg);
        cross_reg <= SUM_W'(axdy_reg) - SUM_W'(aydx_reg);
        len2_reg  <= SQ_W'(dxdx_reg[2*COORD_BITS-1:0]) + SQ_W'(dydy_reg[2*COORD_BITS-1:0]);
        a2_reg    <= SQ_W'(axax_reg[2*COORD_BITS-1:0]) + SQ_W'(ayay_reg[2*COORD_BITS-1:0]);
        b2_reg    <= SQ_W'(bxbx_reg[2*COORD_BITS-1:0]) + SQ_W'(byby_reg[2*COORD_BITS-1:0]);

        entry_reg <= entry_next;
    end

    // classify against the segment parameter range [0, 1]
    always_comb
    begin
        cross_abs            = (cross_reg < 0) ? -cross_reg : cross_reg;
        entry_next.len2      = len2_reg;
        entry_next.cross_mag = cross_abs[SQ_W-1:0];
        entry_next.edist     = a2_reg;
        if (len2_reg == '0)
            entry_next.region = REGION_DEGEN;
        else if (dot_reg < 0)
            entry_next.region = REGION_START;
        else if (dot_reg > signed'(SUM_W'(len2_reg)))
        begin
            entry_next.region = REGION_END;
            entry_next.edist  = b2_reg;
        end
        else
            entry_next.region = REGION_INTERIOR;
    end

    assign entry_valid = v4_reg;
    assign entry       = entry_reg;

endmodule

### rtl/psd_queue.sv
// Short queue between the front end and the divider back end.
module psd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  psd_pkg::entry_t push_data,
    input  logic            pop,
    output psd_pkg::entry_t pop_data,
    output logic            empty,
    output logic            full
);
    import psd_pkg::*;

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_pop;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign do_pop = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = slot_reg[rd_ptr_reg];

endmodule

### rtl/psd_back.sv
// Back end: squares the cross product and runs a pipelined restoring divider.
module psd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  psd_pkg::entry_t                in_entry,
    output logic                           done,
    output logic [psd_pkg::DIST_BITS-1:0]  dist_sq,
    output logic [1:0]                     region
);
    import psd_pkg::*;

    logic            v_reg      [QW+1];
    logic [SQ_W-1:0] rem_reg    [QW+1];
    logic [QW-1:0]   low_reg    [QW+1];
    logic [QW-1:0]   q_reg      [QW+1];
    logic [SQ_W-1:0] den_reg    [QW+1];
    logic [SQ_W-1:0] edist_reg  [QW+1];
    logic [1:0]      region_reg [QW+1];

    logic [2*SQ_W-1:0]    c2;
    logic [NUM_W-1:0]     num;
    logic                 done_reg;
    logic [DIST_BITS-1:0] dist_reg, dist_next;
    logic [1:0]           region_out_reg;
    logic [QW-1:0]        value;
    logic [VAL_W-1:0]     value_w;

    assign c2  = in_entry.cross_mag * in_entry.cross_mag;
    assign num = {c2, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]    <= num[NUM_W-1:QW];
        low_reg[0]    <= num[QW-1:0];
        q_reg[0]      <= '0;
        den_reg[0]    <= in_entry.len2;
        edist_reg[0]  <= in_entry.edist;
        region_reg[0] <= in_entry.region;
    end

    for (genvar i = 1; i <= QW; i++)
    begin : g_div
        logic [SQ_W:0] trial;
        logic          ge;

        assign trial = {rem_reg[i-1], low_reg[i-1][QW-1]};
        assign ge    = (trial >= {1'b0, den_reg[i-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]    <= ge ? SQ_W'(trial - {1'b0, den_reg[i-1]}) : trial[SQ_W-1:0];
            low_reg[i]    <= low_reg[i-1] << 1;
            q_reg[i]      <= {q_reg[i-1][QW-2:0], ge};
            den_reg[i]    <= den_reg[i-1];
            edist_reg[i]  <= edist_reg[i-1];
            region_reg[i] <= region_reg[i-1];
        end
    end

    always_comb
    begin
        if (region_reg[QW] == REGION_INTERIOR)
            value = q_reg[QW];
        else
            value = QW'(edist_reg[QW]) << FRAC_BITS;
        value_w = VAL_W'(value);
        if (value_w > VAL_W'({DIST_BITS{1'b1}}))
            dist_next = '1;
        else
            dist_next = value_w[DIST_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        dist_reg       <= dist_next;
        region_out_reg <= region_reg[QW];
    end

    assign done    = done_reg;
    assign dist_sq = dist_reg;
    assign region  = region_out_reg;

endmodule

### rtl/point_segment_distance_squared.sv
// Top level of the point to segment squared distance block.
//
// Usage:
//   Drive point_x/y, start_x/y and end_x/y and raise start; a transaction is
//   taken at each rising edge where start is high and busy is low. Coordinates
//   are two's complement integers.
//   Each transaction yields one result: done pulses for exactly one cycle with
//   dist_sq (squared distance, 8 fraction bits, rounded down) and region
//   (0 degenerate segment, 1 nearest is start, 2 nearest is end, 3 interior).
//   Throughput: one transaction per cycle, sustained while busy is low.
//   Path: an accepted transaction passes the front end, the queue, the
//   divider input register, the 33-stage divider pipeline, one quotient
//   bit per stage, and the output register before done rises.
//   Structure: a four-stage front end forms differences, products and the
//   region, a short queue holds classified transactions, and the back end
//   squares the cross product and divides it by the squared length.
//   The receiver cannot stall: the back end drains the queue every cycle, so
//   the queue never fills and busy stays low in normal use.
//   Reset clears every valid flag; transactions in flight are dropped.
module point_segment_distance_squared (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [psd_pkg::COORD_BITS-1:0] end_y,
    output logic                                  done,
    output logic [psd_pkg::DIST_BITS-1:0]         dist_sq,
    output logic [1:0]                            region
);
    import psd_pkg::*;

    logic   accept;
    logic   front_valid;
    entry_t front_entry;
    entry_t queue_entry;
    logic   queue_empty;
    logic   queue_full;

    // hold off new transactions only if the queue ever fills
    assign busy   = queue_full;
    assign accept = start && !busy;

    psd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .point_x     (point_x),
        .point_y     (point_y),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .entry_valid (front_valid),
        .entry       (front_entry)
    );

    // advance one entry per cycle into the back end
    psd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_entry),
        .pop       (1'b1),
        .pop_data  (queue_entry),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    psd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!queue_empty),
        .in_entry (queue_entry),
        .done     (done),
        .dist_sq  (dist_sq),
        .region   (region)
    );

endmodule

### rtl/psd_checker.sv
// Port-level checker for the point-segment distance block, with its bind.
module psd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import psd_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the receiver never stalls");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction gave no result at the fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted transaction");

endmodule

bind point_segment_distance_squared psd_checker u_psd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
